### rtl/uve_pkg.sv
// uve_pkg: shared types and constants of the ubjson value encoder
// item kinds, marker letters and the descriptor passed from front to back
// no dependencies
`timescale 1ns / 1ps

package uve_pkg;

  localparam int unsigned KindW = 4;
  localparam int unsigned ValW  = 64;
  localparam int unsigned ByteW = 8;
  localparam int unsigned PfxN  = 5;   // longest marker run: blob header
  localparam int unsigned PfxCntW = 3;
  localparam int unsigned DatCntW = 4;
  localparam int unsigned QDepth  = 2;

  // item kinds
  localparam logic [KindW-1:0] KIND_NULL    = 4'd0;
  localparam logic [KindW-1:0] KIND_BOOL    = 4'd1;
  localparam logic [KindW-1:0] KIND_SINT    = 4'd2;
  localparam logic [KindW-1:0] KIND_UINT    = 4'd3;
  localparam logic [KindW-1:0] KIND_F32     = 4'd4;
  localparam logic [KindW-1:0] KIND_F64     = 4'd5;
  localparam logic [KindW-1:0] KIND_STRHDR  = 4'd6;
  localparam logic [KindW-1:0] KIND_NAMEHDR = 4'd7;
  localparam logic [KindW-1:0] KIND_STRBYTE = 4'd8;
  localparam logic [KindW-1:0] KIND_RAWBYTE = 4'd9;
  localparam logic [KindW-1:0] KIND_ARR_OPN = 4'd10;
  localparam logic [KindW-1:0] KIND_ARR_CLS = 4'd11;
  localparam logic [KindW-1:0] KIND_OBJ_OPN = 4'd12;
  localparam logic [KindW-1:0] KIND_OBJ_CLS = 4'd13;
  localparam logic [KindW-1:0] KIND_BLOBHDR = 4'd14;
  localparam logic [KindW-1:0] KIND_RSVD    = 4'd15;

  // marker letters
  localparam logic [ByteW-1:0] MK_NULL  = 8'h5A;  // Z
  localparam logic [ByteW-1:0] MK_TRUE  = 8'h54;  // T
  localparam logic [ByteW-1:0] MK_FALSE = 8'h46;  // F
  localparam logic [ByteW-1:0] MK_INT8  = 8'h69;  // i
  localparam logic [ByteW-1:0] MK_UINT8 = 8'h55;  // U
  localparam logic [ByteW-1:0] MK_INT16 = 8'h49;  // I
  localparam logic [ByteW-1:0] MK_INT32 = 8'h6C;  // l
  localparam logic [ByteW-1:0] MK_INT64 = 8'h4C;  // L
  localparam logic [ByteW-1:0] MK_F32   = 8'h64;  // d
  localparam logic [ByteW-1:0] MK_F64   = 8'h44;  // D
  localparam logic [ByteW-1:0] MK_CHAR  = 8'h43;  // C
  localparam logic [ByteW-1:0] MK_STR   = 8'h53;  // S
  localparam logic [ByteW-1:0] MK_AOPEN = 8'h5B;  // [
  localparam logic [ByteW-1:0] MK_ACLS  = 8'h5D;  // ]
  localparam logic [ByteW-1:0] MK_OOPEN = 8'h7B;  // {
  localparam logic [ByteW-1:0] MK_OCLS  = 8'h7D;  // }
  localparam logic [ByteW-1:0] MK_TYPE  = 8'h24;  // $
  localparam logic [ByteW-1:0] MK_COUNT = 8'h23;  // #
  localparam logic [ByteW-1:0] SUBST_CHAR = 8'h3F;  // ?

  // work for one item: marker bytes first (element 0 goes out first),
  // then dat_cnt payload bytes taken from the top of dat
  typedef struct packed {
    logic [PfxN-1:0][ByteW-1:0] pfx;
    logic [PfxCntW-1:0]         pfx_cnt;
    logic [ValW-1:0]            dat;
    logic [DatCntW-1:0]         dat_cnt;
  } desc_t;

endpackage

### rtl/uve_if.sv
// uve_item_if / uve_byte_if: valid/ready channels of the ubjson value encoder
// depends on uve_pkg
`timescale 1ns / 1ps

interface uve_item_if;
  import uve_pkg::*;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [ValW-1:0]  value;
  logic [ByteW-1:0] first_char;

  modport source (output valid, kind, value, first_char, input ready);
  modport sink   (input valid, kind, value, first_char, output ready);
endinterface

interface uve_byte_if;
  import uve_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

### rtl/uve_front.sv
// uve_front: classifies an input item into a byte-run descriptor
// depends on uve_pkg; pushes into uve_queue
`timescale 1ns / 1ps

module uve_front import uve_pkg::*; (
  input  logic        kind_valid_i,
  input  logic [KindW-1:0] kind_i,
  input  logic [ValW-1:0]  value_i,
  input  logic [ByteW-1:0] first_char_i,
  output logic        item_ready_o,
  input  logic        q_full_i,
  output logic        push_o,
  output desc_t       desc_o
);

  logic [ByteW-1:0]   u_mark, s_mark, lo;
  logic [DatCntW-1:0] u_cnt, s_cnt;
  logic               is_char;

  assign lo = value_i[ByteW-1:0];

  // unsigned / length size selection
  always_comb begin
    if (value_i[63:8] == '0) begin
      u_mark = MK_UINT8; u_cnt = 4'd1;
    end else if (value_i[63:15] == '0) begin
      u_mark = MK_INT16; u_cnt = 4'd2;
    end else if (value_i[63:31] == '0) begin
      u_mark = MK_INT32; u_cnt = 4'd4;
    end else begin
      u_mark = MK_INT64; u_cnt = 4'd8;
    end
  end

  // signed size selection: fits when the sign bits above the width agree
  always_comb begin
    if (value_i[63:7] == '0 || value_i[63:7] == '1) begin
      s_mark = MK_INT8; s_cnt = 4'd1;
    end else if (value_i[63:8] == '0) begin
      s_mark = MK_UINT8; s_cnt = 4'd1;
    end else if (value_i[63:15] == '0 || value_i[63:15] == '1) begin
      s_mark = MK_INT16; s_cnt = 4'd2;
    end else if (value_i[63:31] == '0 || value_i[63:31] == '1) begin
      s_mark = MK_INT32; s_cnt = 4'd4;
    end else begin
      s_mark = MK_INT64; s_cnt = 4'd8;
    end
  end

  assign is_char = (value_i == 64'd1) && !first_char_i[7];

  always_comb begin
    desc_o.pfx     = '0;
    desc_o.pfx_cnt = 3'd1;
    desc_o.dat_cnt = 4'd0;
    case (kind_i)
      KIND_NULL: desc_o.pfx[0] = MK_NULL;
      KIND_BOOL: desc_o.pfx[0] = (value_i != '0) ? MK_TRUE : MK_FALSE;
      KIND_SINT: begin
        desc_o.pfx[0] = s_mark; desc_o.dat_cnt = s_cnt;
      end
      KIND_UINT, KIND_NAMEHDR: begin
        desc_o.pfx[0] = u_mark; desc_o.dat_cnt = u_cnt;
      end
      KIND_F32: begin
        desc_o.pfx[0] = MK_F32; desc_o.dat_cnt = 4'd4;
      end
      KIND_F64: begin
        desc_o.pfx[0] = MK_F64; desc_o.dat_cnt = 4'd8;
      end
      KIND_STRHDR: begin
        desc_o.pfx_cnt = 3'd2;
        if (is_char) begin
          desc_o.pfx[0] = MK_CHAR; desc_o.pfx[1] = first_char_i;
        end else begin
          desc_o.pfx[0] = MK_STR; desc_o.pfx[1] = u_mark; desc_o.dat_cnt = u_cnt;
        end
      end
      KIND_STRBYTE: desc_o.pfx[0] = lo[7] ? SUBST_CHAR : lo;
      KIND_RAWBYTE: desc_o.pfx[0] = lo;
      KIND_ARR_OPN: desc_o.pfx[0] = MK_AOPEN;
      KIND_ARR_CLS: desc_o.pfx[0] = MK_ACLS;
      KIND_OBJ_OPN: desc_o.pfx[0] = MK_OOPEN;
      KIND_OBJ_CLS: desc_o.pfx[0] = MK_OCLS;
      KIND_BLOBHDR: begin
        desc_o.pfx[0] = MK_AOPEN; desc_o.pfx[1] = MK_TYPE;
        desc_o.pfx[2] = MK_UINT8; desc_o.pfx[3] = MK_COUNT;
        desc_o.pfx[4] = u_mark;   desc_o.pfx_cnt = 3'd5;
        desc_o.dat_cnt = u_cnt;
      end
      default: desc_o.pfx_cnt = 3'd0;
    endcase

    // payload left-aligned so the back end always sends the top byte
    case (desc_o.dat_cnt)
      4'd1:    desc_o.dat = {value_i[7:0], 56'd0};
      4'd2:    desc_o.dat = {value_i[15:0], 48'd0};
      4'd4:    desc_o.dat = {value_i[31:0], 32'd0};
      4'd8:    desc_o.dat = value_i;
      default: desc_o.dat = '0;
    endcase
  end

  // reserved kind is taken and dropped
  assign item_ready_o = !q_full_i;
  assign push_o       = kind_valid_i && !q_full_i && (kind_i != KIND_RSVD);

endmodule

### rtl/uve_queue.sv
// uve_queue: two-entry descriptor queue between front and back
// depends on uve_pkg
`timescale 1ns / 1ps

module uve_queue import uve_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  input  logic  pop_i,
  output desc_t desc_o,
  output logic  full_o,
  output logic  avail_o
);

  localparam int unsigned PtrW = $clog2(QDepth);

  desc_t             mem_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(QDepth));
  assign avail_o = (cnt_q != '0);
  assign desc_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !avail_o))
    else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QDepth))
    else $error("queue count out of range");

endmodule

### rtl/uve_back.sv
// uve_back: serializes one descriptor into bytes behind an output register
// depends on uve_pkg; pops from uve_queue
`timescale 1ns / 1ps

module uve_back import uve_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  avail_i,
  input  desc_t desc_i,
  output logic  pop_o,
  output logic  byte_valid_o,
  output logic [ByteW-1:0] byte_o,
  output logic  last_o,
  input  logic  byte_ready_i
);

  logic                       busy_q, busy_d;
  logic [PfxN-1:0][ByteW-1:0] pfx_q, pfx_d;
  logic [PfxCntW-1:0]         pcnt_q, pcnt_d;
  logic [ValW-1:0]            dat_q, dat_d;
  logic [DatCntW-1:0]         dcnt_q, dcnt_d;
  logic                       ovalid_q, ovalid_d;
  logic [ByteW-1:0]           obyte_q, obyte_d;
  logic                       olast_q, olast_d;
  logic                       adv, cur_last, load;
  logic [ByteW-1:0]           cur_byte;

  assign adv      = !ovalid_q || byte_ready_i;
  assign cur_byte = (pcnt_q != '0) ? pfx_q[0] : dat_q[ValW-1 -: ByteW];
  assign cur_last = ((DatCntW)'(pcnt_q) + dcnt_q) == (DatCntW)'(1);
  // next descriptor is loaded when idle or while the last byte leaves
  assign load     = avail_i && (!busy_q || (adv && cur_last));
  assign pop_o    = load;

  always_comb begin
    busy_d = busy_q;
    pfx_d  = pfx_q;
    pcnt_d = pcnt_q;
    dat_d  = dat_q;
    dcnt_d = dcnt_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    if (adv) begin
      ovalid_d = busy_q;
      obyte_d  = cur_byte;
      olast_d  = cur_last;
    end
    if (busy_q && adv) begin
      if (pcnt_q != '0) begin
        pfx_d  = pfx_q >> ByteW;
        pcnt_d = pcnt_q - 1'b1;
      end else begin
        dat_d  = dat_q << ByteW;
        dcnt_d = dcnt_q - 1'b1;
      end
      if (cur_last) busy_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      pfx_d  = desc_i.pfx;
      pcnt_d = desc_i.pfx_cnt;
      dat_d  = desc_i.dat;
      dcnt_d = desc_i.dat_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pcnt_q   <= '0;
      dcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      pcnt_q   <= pcnt_d;
      dcnt_q   <= dcnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pfx_q   <= pfx_d;
    dat_q   <= dat_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign byte_valid_o = ovalid_q;
  assign byte_o       = obyte_q;
  assign last_o       = olast_q;

  a_busy_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pcnt_q != '0 || dcnt_q != '0))
    else $error("busy with no bytes left");
  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && adv && cur_last && !avail_i) |=> !busy_q)
    else $error("busy after last byte with empty queue");
  a_emit_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !busy_q) |=> !ovalid_q)
    else $error("byte produced while idle");

endmodule

### rtl/ubjson_value_encoder_top.sv
// ubjson_value_encoder_top: ubjson value encoder, front/queue/back
// depends on uve_pkg, uve_if, uve_front, uve_queue, uve_back
//
//  channel   dir  payload                     meaning
//  item_i    in   kind, value, first_char     one value item
//  byte_o    out  out_byte, last              one encoded byte, last marks end
//
// an item is classified in the cycle it is accepted and queued (two entries)
// the back end sends one byte per cycle while the sink is ready; an item gives
// 1 to 13 bytes; one-byte items stream at one per cycle while the sink is ready
// input is taken whenever the queue has room, also while output is stalled
// reserved kind is accepted and gives no bytes; reset clears queue and back end
`timescale 1ns / 1ps

module ubjson_value_encoder_top import uve_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  uve_item_if.sink   item_i,
  uve_byte_if.source byte_o
);

  logic   q_push, q_full, q_pop, q_avail;
  desc_t  front_desc, q_desc;

  uve_front u_front (
    .kind_valid_i (item_i.valid),
    .kind_i       (item_i.kind),
    .value_i      (item_i.value),
    .first_char_i (item_i.first_char),
    .item_ready_o (item_i.ready),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .desc_o       (front_desc)
  );

  uve_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (front_desc),
    .pop_i   (q_pop),
    .desc_o  (q_desc),
    .full_o  (q_full),
    .avail_o (q_avail)
  );

  uve_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (q_avail),
    .desc_i       (q_desc),
    .pop_o        (q_pop),
    .byte_valid_o (byte_o.valid),
    .byte_o       (byte_o.out_byte),
    .last_o       (byte_o.last),
    .byte_ready_i (byte_o.ready)
  );

endmodule

### dv/ubjson_value_encoder_top_tb.sv
// ubjson_value_encoder_top_tb: checks the encoded byte stream of the ubjson value encoder
// directed edge cases and random documents; bursty requests, stalling sink, one long hold-off
// depends on uve_pkg, uve_if and ubjson_value_encoder_top
`timescale 1ns / 1ps

module ubjson_value_encoder_top_tb;
  import uve_pkg::*;

  localparam int QuietLimit = 3000;
  localparam int DrainCycles = 30;
  localparam int RandomItems = 80;

  typedef struct packed {
    logic [ByteW-1:0] code;
    logic             last;
  } enc_byte_t;

  logic clk_i;
  logic rst_ni;

  uve_item_if item_if ();
  uve_byte_if byte_if ();

  ubjson_value_encoder_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .byte_o (byte_if)
  );

  enc_byte_t        expected_bytes[$];
  logic [ByteW-1:0] staged[$];
  enc_byte_t        due_byte;
  int               err_cnt = 0;
  int               items_sent = 0;
  int               burst_left = 0;
  int               quiet_cycles = 0;
  int               hold_request = 0;
  int               hold_left = 0;
  int               stall_mode = 0;
  int               mode_left = 0;
  int               pat_pos = 0;
  logic [7:0]       stall_pattern = 8'hFF;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // encoding predictor
  // ---------------------------------------------------------------------------
  function automatic void stage_be(input logic [ValW-1:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) begin
      staged.push_back(v[8*i +: 8]);
    end
  endfunction

  function automatic void stage_uint(input logic [ValW-1:0] v);
    if (v <= 64'hFF) begin
      staged.push_back(MK_UINT8);
      stage_be(v, 1);
    end else if (v <= 64'h7FFF) begin
      staged.push_back(MK_INT16);
      stage_be(v, 2);
    end else if (v <= 64'h7FFF_FFFF) begin
      staged.push_back(MK_INT32);
      stage_be(v, 4);
    end else begin
      staged.push_back(MK_INT64);
      stage_be(v, 8);
    end
  endfunction

  // range checks by offset and unsigned compare, wrapping at 64 bits
  function automatic void stage_sint(input logic [ValW-1:0] v);
    logic [ValW-1:0] off8, off16, off32;
    off8  = v + 64'h80;
    off16 = v + 64'h8000;
    off32 = v + 64'h8000_0000;
    if (off8 <= 64'hFF) begin
      staged.push_back(MK_INT8);
      stage_be(v, 1);
    end else if (v <= 64'hFF) begin
      staged.push_back(MK_UINT8);
      stage_be(v, 1);
    end else if (off16 <= 64'hFFFF) begin
      staged.push_back(MK_INT16);
      stage_be(v, 2);
    end else if (off32 <= 64'hFFFF_FFFF) begin
      staged.push_back(MK_INT32);
      stage_be(v, 4);
    end else begin
      staged.push_back(MK_INT64);
      stage_be(v, 8);
    end
  endfunction

  function automatic void encode_item(input logic [KindW-1:0] kind,
                                      input logic [ValW-1:0] value,
                                      input logic [ByteW-1:0] fc);
    enc_byte_t eb;
    staged.delete();
    case (kind)
      KIND_NULL:    staged.push_back(MK_NULL);
      KIND_BOOL:    staged.push_back((value != '0) ? MK_TRUE : MK_FALSE);
      KIND_SINT:    stage_sint(value);
      KIND_UINT:    stage_uint(value);
      KIND_F32: begin
        staged.push_back(MK_F32);
        stage_be({32'h0, value[31:0]}, 4);
      end
      KIND_F64: begin
        staged.push_back(MK_F64);
        stage_be(value, 8);
      end
      KIND_STRHDR: begin
        if (value == 64'd1 && fc < 8'h80) begin
          staged.push_back(MK_CHAR);
          staged.push_back(fc);
        end else begin
          staged.push_back(MK_STR);
          stage_uint(value);
        end
      end
      KIND_NAMEHDR: stage_uint(value);
      KIND_STRBYTE: staged.push_back((value[7:0] < 8'h80) ? value[7:0] : SUBST_CHAR);
      KIND_RAWBYTE: staged.push_back(value[7:0]);
      KIND_ARR_OPN: staged.push_back(MK_AOPEN);
      KIND_ARR_CLS: staged.push_back(MK_ACLS);
      KIND_OBJ_OPN: staged.push_back(MK_OOPEN);
      KIND_OBJ_CLS: staged.push_back(MK_OCLS);
      KIND_BLOBHDR: begin
        staged.push_back(MK_AOPEN);
        staged.push_back(MK_TYPE);
        staged.push_back(MK_UINT8);
        staged.push_back(MK_COUNT);
        stage_uint(value);
      end
      default: ;  // reserved kind gives no bytes
    endcase
    for (int i = 0; i < staged.size(); i++) begin
      eb.code = staged[i];
      eb.last = (i == staged.size() - 1);
      expected_bytes.push_back(eb);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // request side: called and returns at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [KindW-1:0] kind, input logic [ValW-1:0] value,
                           input logic [ByteW-1:0] fc);
    if (burst_left == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
    item_if.valid      <= 1'b1;
    item_if.kind       <= kind;
    item_if.value      <= value;
    item_if.first_char <= fc;
    @(posedge clk_i);
    while (item_if.ready !== 1'b1) @(posedge clk_i);
    encode_item(kind, value, fc);
    items_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // biased toward the integer class boundaries and small negatives
  function automatic logic [ValW-1:0] pick_value();
    logic [ValW-1:0] r, b;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return r;
      1: return r >> $urandom_range(1, 63);
      2: return -(r >> $urandom_range(33, 63));
      3: begin
        b = (64'd1 << $urandom_range(7, 63)) + 64'($urandom_range(0, 2)) - 64'd1;
        return ($urandom_range(0, 1) != 0) ? -b : b;
      end
      default: return r & 64'hFF;
    endcase
  endfunction

  task automatic send_random_item(input int kind_lo, input int kind_hi);
    logic [KindW-1:0] kind;
    logic [ValW-1:0]  value;
    kind  = KindW'($urandom_range(kind_lo, kind_hi));
    value = pick_value();
    if (kind == KIND_STRHDR && $urandom_range(0, 1) != 0) value = 64'd1;
    send_item(kind, value, ByteW'($urandom_range(0, 255)));
  endtask

  // header and body bytes; a one-char ascii string carries no body
  task automatic send_string(input logic [KindW-1:0] hdr_kind);
    int               len;
    logic [ByteW-1:0] c;
    len = $urandom_range(0, 5);
    c   = ($urandom_range(0, 3) == 0) ? ByteW'($urandom_range(128, 255))
                                      : ByteW'($urandom_range(32, 126));
    send_item(hdr_kind, ValW'(len), c);
    if (!(hdr_kind == KIND_STRHDR && len == 1 && c < 8'h80)) begin
      for (int i = 0; i < len; i++) begin
        send_item(KIND_STRBYTE, (i == 0) ? {56'h0, c} : {$urandom, $urandom},
                  ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sink side: stall pattern and long hold-off, both counted here
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_pattern = 8'($urandom) | 8'h01;
      mode_left = $urandom_range(10, 60);
    end
    mode_left--;
    if (hold_left > 0) begin
      byte_if.ready <= 1'b0;
      hold_left--;
    end else begin
      case (stall_mode)
        0: byte_if.ready <= 1'b1;
        1: byte_if.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          byte_if.ready <= stall_pattern[pat_pos];
          pat_pos = (pat_pos + 1) % 8;
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && byte_if.valid === 1'b1 && byte_if.ready === 1'b1) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte: out_byte %h last %b", byte_if.out_byte, byte_if.last);
        err_cnt++;
      end else begin
        due_byte = expected_bytes.pop_front();
        if (byte_if.out_byte !== due_byte.code) begin
          $error("out_byte: expected %h, actual %h", due_byte.code, byte_if.out_byte);
          err_cnt++;
        end
        if (byte_if.last !== due_byte.last) begin
          $error("last: expected %b, actual %b", due_byte.last, byte_if.last);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no request or byte moving
  always @(posedge clk_i) begin
    if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
        (byte_if.valid === 1'b1 && byte_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_markers();
    send_item(KIND_NULL, 64'h0, 8'h00);
    send_item(KIND_BOOL, 64'h0, 8'h00);
    send_item(KIND_BOOL, 64'h8000_0000_0000_0000, 8'hFF);
    send_item(KIND_ARR_OPN, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    send_item(KIND_ARR_CLS, 64'h0, 8'h00);
    send_item(KIND_OBJ_OPN, 64'h0, 8'h00);
    send_item(KIND_OBJ_CLS, 64'h0, 8'h00);
    send_item(KIND_RSVD, 64'h1234, 8'h41);
  endtask

  task automatic test_integers();
    send_item(KIND_SINT, 64'hFFFF_FFFF_FFFF_FF80, 8'h00);  // -128
    send_item(KIND_SINT, 64'd255, 8'h00);
    send_item(KIND_SINT, 64'hFFFF_FFFF_FFFF_8000, 8'h00);  // -32768
    send_item(KIND_SINT, 64'd32768, 8'h00);
    send_item(KIND_SINT, 64'h8000_0000_0000_0000, 8'h00);
    send_item(KIND_UINT, 64'h7FFF, 8'h00);
    send_item(KIND_UINT, 64'h8000_0000, 8'h00);
    send_item(KIND_UINT, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);  // above int64 max
  endtask

  task automatic test_floats();
    send_item(KIND_F32, 64'hFFFF_FFFF_3F80_0000, 8'h00);  // upper half ignored
    send_item(KIND_F64, 64'hC009_21FB_5444_2D18, 8'h00);
  endtask

  task automatic test_strings_and_blobs();
    send_item(KIND_STRHDR, 64'd1, 8'h41);
    send_item(KIND_STRHDR, 64'd1, 8'h80);
    send_item(KIND_STRHDR, 64'h8000, 8'h7F);
    send_item(KIND_NAMEHDR, 64'd255, 8'h00);
    send_item(KIND_STRBYTE, 64'hFFFF_FFFF_FFFF_FF80, 8'h00);
    send_item(KIND_STRBYTE, 64'h7F, 8'h00);
    send_item(KIND_RAWBYTE, 64'hFF, 8'h00);
    send_item(KIND_BLOBHDR, 64'h1_0000_0000, 8'h00);
  endtask

  task automatic test_random_documents();
    int target;
    int n;
    target = items_sent + RandomItems;
    while (items_sent < target) begin
      case ($urandom_range(0, 5))
        0: send_string(KIND_STRHDR);
        1: begin
          send_item(KIND_OBJ_OPN, pick_value(), ByteW'($urandom_range(0, 255)));
          repeat ($urandom_range(0, 3)) begin
            send_string(KIND_NAMEHDR);
            send_random_item(KIND_NULL, KIND_F64);
          end
          send_item(KIND_OBJ_CLS, pick_value(), ByteW'($urandom_range(0, 255)));
        end
        2: begin
          send_item(KIND_ARR_OPN, pick_value(), ByteW'($urandom_range(0, 255)));
          repeat ($urandom_range(0, 4)) send_random_item(KIND_NULL, KIND_F64);
          send_item(KIND_ARR_CLS, pick_value(), ByteW'($urandom_range(0, 255)));
        end
        3: begin
          n = $urandom_range(0, 4);
          send_item(KIND_BLOBHDR, ValW'(n), ByteW'($urandom_range(0, 255)));
          repeat (n) send_item(KIND_RAWBYTE, {$urandom, $urandom}, ByteW'($urandom_range(0, 255)));
        end
        4: send_random_item(KIND_NULL, KIND_F64);
        default: send_random_item(KIND_NULL, KIND_RSVD);
      endcase
    end
  endtask

  // sink holds off while requests keep coming, so the queue fills and input stalls
  task automatic test_output_backpressure();
    hold_request = 150;
    burst_left = 40;
    repeat (12) send_random_item(KIND_SINT, KIND_BLOBHDR);
  endtask

  initial begin
    rst_ni             = 1'b0;
    item_if.valid      = 1'b0;
    item_if.kind       = KIND_NULL;
    item_if.value      = '0;
    item_if.first_char = '0;
    byte_if.ready      = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_markers();
    test_integers();
    test_floats();
    test_strings_and_blobs();
    test_output_backpressure();
    test_random_documents();

    item_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/uve_pkg.sv
rtl/uve_if.sv
rtl/uve_front.sv
rtl/uve_queue.sv
rtl/uve_back.sv
rtl/ubjson_value_encoder_top.sv
dv/ubjson_value_encoder_top_tb.sv
